>>> rtl/core/bgd_pkg.sv
package bgd_pkg;

   localparam int TIME_WIDTH_DEFAULT = 16;
   localparam int LIMIT_WIDTH        = 16;
   localparam int CSR_INDEX_WIDTH    = 2;
   localparam int CSR_DATA_WIDTH     = 16;
   localparam int EVENT_WIDTH        = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVE_LEVEL = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOUBLE_CLICK = 2'd2;

   localparam logic                   ACTIVE_LEVEL_RESET = 1'b0;
   localparam logic [LIMIT_WIDTH-1:0] LONG_PRESS_RESET   = 16'd5000;
   localparam logic [LIMIT_WIDTH-1:0] DOUBLE_CLICK_RESET = 16'd500;

   typedef enum logic [EVENT_WIDTH-1:0] {
      EV_DOWN   = 2'd0,
      EV_UP     = 2'd1,
      EV_LONG   = 2'd2,
      EV_DOUBLE = 2'd3
   } event_type;

   typedef struct packed {
      logic                   active_level;
      logic [LIMIT_WIDTH-1:0] long_press_ticks;
      logic [LIMIT_WIDTH-1:0] double_click_ticks;
   } cfg_type;

   typedef struct packed {
      logic      valid;
      event_type code;
   } evt_type;

endpackage

>>> rtl/core/bgd_csr.sv
module bgd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bgd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bgd_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output bgd_pkg::cfg_type                     cfg
);

   bgd_pkg::cfg_type cfg_ff;
   bgd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bgd_pkg::CSR_ACTIVE_LEVEL: cfg_in.active_level       = csr_data[0];
            bgd_pkg::CSR_LONG_PRESS:   cfg_in.long_press_ticks   = csr_data;
            bgd_pkg::CSR_DOUBLE_CLICK: cfg_in.double_click_ticks = csr_data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level       <= bgd_pkg::ACTIVE_LEVEL_RESET;
         cfg_ff.long_press_ticks   <= bgd_pkg::LONG_PRESS_RESET;
         cfg_ff.double_click_ticks <= bgd_pkg::DOUBLE_CLICK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/bgd_fsm.sv
module bgd_fsm #(
   parameter int TIME_WIDTH = bgd_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             level,
   input  bgd_pkg::cfg_type cfg,
   output bgd_pkg::evt_type evt
);

   localparam int CMP_WIDTH = (TIME_WIDTH > bgd_pkg::LIMIT_WIDTH) ?
                              TIME_WIDTH : bgd_pkg::LIMIT_WIDTH;

   typedef enum logic [2:0] {
      MODE_START  = 3'd0,
      MODE_UP     = 3'd1,
      MODE_DOWN   = 3'd2,
      MODE_LONG   = 3'd3,
      MODE_DOUBLE = 3'd4
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [TIME_WIDTH-1:0] elapsed_inc;
   logic [CMP_WIDTH-1:0]  elapsed_cmp, long_cmp, double_cmp;
   logic                  pressed;

   assign pressed     = (level == cfg.active_level);
   assign elapsed_inc = (elapsed_ff == {TIME_WIDTH{1'b1}}) ? elapsed_ff :
                        elapsed_ff + {{(TIME_WIDTH-1){1'b0}}, 1'b1};
   assign elapsed_cmp = CMP_WIDTH'(elapsed_inc);
   assign long_cmp    = CMP_WIDTH'(cfg.long_press_ticks);
   assign double_cmp  = CMP_WIDTH'(cfg.double_click_ticks);

   always_comb begin
      mode_in    = mode_ff;
      elapsed_in = elapsed_inc;
      evt.valid  = 1'b0;
      evt.code   = bgd_pkg::EV_DOWN;
      unique case (mode_ff)
         MODE_DOWN: begin
            if (elapsed_cmp > long_cmp) begin
               evt.valid = 1'b1;
               evt.code  = bgd_pkg::EV_LONG;
               mode_in   = MODE_LONG;
            end else if (!pressed) begin
               evt.valid = 1'b1;
               evt.code  = bgd_pkg::EV_UP;
               mode_in   = MODE_UP;
            end
         end
         MODE_UP: begin
            if (pressed) begin
               evt.valid = 1'b1;
               if (elapsed_cmp >= double_cmp) begin
                  evt.code = bgd_pkg::EV_DOWN;
                  mode_in  = MODE_DOWN;
               end else begin
                  evt.code = bgd_pkg::EV_DOUBLE;
                  mode_in  = MODE_DOUBLE;
               end
            end
         end
         MODE_LONG, MODE_DOUBLE: begin
            if (!pressed) begin
               evt.valid = 1'b1;
               evt.code  = bgd_pkg::EV_UP;
               mode_in   = MODE_UP;
            end
         end
         default: begin
            // first tick: classify only
            mode_in    = pressed ? MODE_DOWN : MODE_UP;
            elapsed_in = '0;
         end
      endcase
      if (evt.valid) begin
         elapsed_in = '0;
      end
      if (!accept) begin
         evt.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_START;
         elapsed_ff <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
      end
   end

   a_evt_needs_accept: assert property (@(posedge clock) disable iff (reset)
      evt.valid |-> accept)
      else $error("event raised without an accepted tick");

   a_evt_clears_count: assert property (@(posedge clock) disable iff (reset)
      evt.valid |=> elapsed_ff == '0)
      else $error("tick count not cleared after an event");

   a_long_from_down: assert property (@(posedge clock) disable iff (reset)
      (evt.valid && evt.code == bgd_pkg::EV_LONG) |-> mode_ff == MODE_DOWN)
      else $error("long press outside down mode");

   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_START) |-> !evt.valid)
      else $error("event on the first tick");

endmodule

>>> rtl/core/button_gesture_detector.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    req_level (1 bit, sampled pin level)
// rsp_      out        rsp_valid/rsp_ready    rsp_event_code (2 bits)
// csr_      in         csr_valid/csr_ready    csr_index (2 bits), csr_data (16 bits)
//
// One tick word per cycle while req_ready is high; an event word appears in the rsp_
// register in the cycle after its tick is accepted. The state update is a single compare
// and increment, so the mode/count registers do not limit the tick rate.
// Reset is synchronous, active high; it restores the register defaults and
// the start mode. req_ready drops only while an event word is held in the
// rsp_ register and rsp_ready is low. csr_ready is always high.
module button_gesture_detector #(
   parameter int TIME_WIDTH = bgd_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bgd_pkg::EVENT_WIDTH-1:0]     rsp_event_code,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bgd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bgd_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   bgd_pkg::cfg_type cfg;
   bgd_pkg::evt_type evt;
   logic             accept;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bgd_pkg::EVENT_WIDTH-1:0]   rsp_code_ff, rsp_code_in;

   bgd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bgd_fsm #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_fsm (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .level  (req_level),
      .cfg    (cfg),
      .evt    (evt)
   );

   // take a tick whenever the result slot is empty or draining this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_code_in  = rsp_code_ff;
      if (evt.valid) begin
         // load a fresh event word; ticks without an event leave the slot alone
         rsp_valid_in = 1'b1;
         rsp_code_in  = evt.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_code_ff;

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff)
      else $error("input stalled with an empty result slot");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_code_ff)))
      else $error("pending event word lost");

   a_event_lands: assert property (@(posedge clock) disable iff (reset)
      evt.valid |=> (rsp_valid_ff && rsp_code_ff == $past(evt.code)))
      else $error("event word not loaded");

endmodule

>>> bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // No register sits at the spare index; a write there must change nothing.
   localparam logic [bgd_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   localparam int TICK_WIDTH      = bgd_pkg::TIME_WIDTH_DEFAULT;
   localparam int IDLE_MAX        = 18;
   localparam int QUIET_LIMIT     = 2000;   // cycles with no handshake at all
   localparam int HOLD_AT_EVENT   = 60;     // event count at which the receiver backs off
   localparam int HOLD_CYCLES     = 300;
   localparam int RANDOM_TICKS    = 1830;

   // Gesture state mirrored by the predictor.
   typedef enum logic [2:0] {
      MODE_START  = 3'd0,
      MODE_UP     = 3'd1,
      MODE_DOWN   = 3'd2,
      MODE_LONG   = 3'd3,
      MODE_DOUBLE = 3'd4
   } gesture_mode_type;

   // Directed rows: a register write, a tick whose outcome is typed in by hand
   // (quiet or a given event), or a tick left to the predictor.
   typedef enum logic [1:0] {
      DO_CSR         = 2'd0,
      TICK_QUIET     = 2'd1,
      TICK_EVENT     = 2'd2,
      TICK_PREDICTED = 2'd3
   } row_kind_type;

   typedef struct packed {
      row_kind_type                        kind;
      logic [bgd_pkg::CSR_INDEX_WIDTH-1:0] index;
      logic [bgd_pkg::CSR_DATA_WIDTH-1:0]  data;
      logic                                level;
      bgd_pkg::event_type                  code;
   } script_row_type;

   // Reset defaults are active low, long press after 5000 ticks, double click under 500.
   script_row_type directed_script [29] = '{
      // start tick: released pin only classifies the mode as up
      '{TICK_QUIET,     '0,                        16'h0000, 1'b1, bgd_pkg::EV_DOWN},
      // press one tick after start is well under the double-click window
      '{TICK_EVENT,     '0,                        16'h0000, 1'b0, bgd_pkg::EV_DOUBLE},
      '{TICK_EVENT,     '0,                        16'h0000, 1'b1, bgd_pkg::EV_UP},
      // upper data bits are ignored, so this keeps the pin active low
      '{DO_CSR,         bgd_pkg::CSR_ACTIVE_LEVEL, 16'hFFFE, 1'b0, bgd_pkg::EV_DOWN},
      '{DO_CSR,         bgd_pkg::CSR_LONG_PRESS,   16'h0000, 1'b0, bgd_pkg::EV_DOWN},
      '{DO_CSR,         bgd_pkg::CSR_DOUBLE_CLICK, 16'h0000, 1'b0, bgd_pkg::EV_DOWN},
      // zero limits: every press is a plain down, the next held tick is long
      '{TICK_EVENT,     '0,                        16'h0000, 1'b0, bgd_pkg::EV_DOWN},
      '{TICK_EVENT,     '0,                        16'h0000, 1'b0, bgd_pkg::EV_LONG},
      '{TICK_QUIET,     '0,                        16'h0000, 1'b0, bgd_pkg::EV_DOWN},
      '{TICK_EVENT,     '0,                        16'h0000, 1'b1, bgd_pkg::EV_UP},
      // switch to active high with small limits
      '{DO_CSR,         bgd_pkg::CSR_ACTIVE_LEVEL, 16'h0001, 1'b0, bgd_pkg::EV_DOWN},
      '{DO_CSR,         bgd_pkg::CSR_LONG_PRESS,   16'h0002, 1'b0, bgd_pkg::EV_DOWN},
      '{DO_CSR,         bgd_pkg::CSR_DOUBLE_CLICK, 16'h0003, 1'b0, bgd_pkg::EV_DOWN},
      '{TICK_QUIET,     '0,                        16'h0000, 1'b0, bgd_pkg::EV_DOWN},
      '{TICK_EVENT,     '0,                        16'h0000, 1'b1, bgd_pkg::EV_DOUBLE},
      '{TICK_QUIET,     '0,                        16'h0000, 1'b1, bgd_pkg::EV_DOWN},
      '{TICK_EVENT,     '0,                        16'h0000, 1'b0, bgd_pkg::EV_UP},
      '{TICK_QUIET,     '0,                        16'h0000, 1'b0, bgd_pkg::EV_DOWN},
      '{TICK_QUIET,     '0,                        16'h0000, 1'b0, bgd_pkg::EV_DOWN},
      // press exactly at the double-click limit is a plain down
      '{TICK_EVENT,     '0,                        16'h0000, 1'b1, bgd_pkg::EV_DOWN},
      '{TICK_QUIET,     '0,                        16'h0000, 1'b1, bgd_pkg::EV_DOWN},
      '{TICK_QUIET,     '0,                        16'h0000, 1'b1, bgd_pkg::EV_DOWN},
      // release on the tick that crosses the long limit: long press wins
      '{TICK_EVENT,     '0,                        16'h0000, 1'b0, bgd_pkg::EV_LONG},
      '{TICK_EVENT,     '0,                        16'h0000, 1'b0, bgd_pkg::EV_UP},
      // spare index writes nothing; then both limits at their maximum
      '{DO_CSR,         CSR_SPARE,                 16'hFFFF, 1'b0, bgd_pkg::EV_DOWN},
      '{DO_CSR,         bgd_pkg::CSR_LONG_PRESS,   16'hFFFF, 1'b0, bgd_pkg::EV_DOWN},
      '{DO_CSR,         bgd_pkg::CSR_DOUBLE_CLICK, 16'hFFFF, 1'b0, bgd_pkg::EV_DOWN},
      '{TICK_PREDICTED, '0,                        16'h0000, 1'b1, bgd_pkg::EV_DOWN},
      '{TICK_PREDICTED, '0,                        16'h0000, 1'b0, bgd_pkg::EV_DOWN}
   };

   logic                                clock          = 1'b0;
   logic                                reset          = 1'b1;
   logic                                req_valid      = 1'b0;
   logic                                req_ready;
   logic                                req_level      = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready      = 1'b0;
   logic [bgd_pkg::EVENT_WIDTH-1:0]     rsp_event_code;
   logic                                csr_valid      = 1'b0;
   logic                                csr_ready;
   logic [bgd_pkg::CSR_INDEX_WIDTH-1:0] csr_index      = '0;
   logic [bgd_pkg::CSR_DATA_WIDTH-1:0]  csr_data       = '0;

   // Predictor copy of the registers and the gesture state.
   logic                            cfg_active     = bgd_pkg::ACTIVE_LEVEL_RESET;
   logic [bgd_pkg::LIMIT_WIDTH-1:0] cfg_long       = bgd_pkg::LONG_PRESS_RESET;
   logic [bgd_pkg::LIMIT_WIDTH-1:0] cfg_double     = bgd_pkg::DOUBLE_CLICK_RESET;
   gesture_mode_type                press_mode     = MODE_START;
   logic [TICK_WIDTH-1:0]           ticks_since    = '0;

   bgd_pkg::event_type              pending_events [$];
   int                              mismatches     = 0;
   int                              events_seen    = 0;
   int                              quiet_cycles   = 0;
   int                              send_cap       = IDLE_MAX;
   int                              recv_cap       = IDLE_MAX;
   logic                            last_level     = 1'b1;

   button_gesture_detector i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_level      (req_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_code (rsp_event_code),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   // Advance the gesture state by one tick and report the event it causes, if any.
   function automatic void advance_gesture(input logic lvl, output bit fires,
                                           output bgd_pkg::event_type code);
      logic pressed;
      pressed = (lvl == cfg_active);
      fires   = 1'b0;
      code    = bgd_pkg::EV_DOWN;
      if (press_mode == MODE_START) begin
         press_mode  = pressed ? MODE_DOWN : MODE_UP;
         ticks_since = '0;
         return;
      end
      // saturate rather than wrap
      if (ticks_since != '1) begin
         ticks_since = ticks_since + 1'b1;
      end
      case (press_mode)
         MODE_DOWN: begin
            if (ticks_since > cfg_long) begin
               fires      = 1'b1;
               code       = bgd_pkg::EV_LONG;
               press_mode = MODE_LONG;
            end else if (!pressed) begin
               fires      = 1'b1;
               code       = bgd_pkg::EV_UP;
               press_mode = MODE_UP;
            end
         end
         MODE_UP: begin
            if (pressed) begin
               fires      = 1'b1;
               code       = (ticks_since >= cfg_double) ? bgd_pkg::EV_DOWN
                                                        : bgd_pkg::EV_DOUBLE;
               press_mode = (ticks_since >= cfg_double) ? MODE_DOWN : MODE_DOUBLE;
            end
         end
         default: begin
            if (!pressed) begin
               fires      = 1'b1;
               code       = bgd_pkg::EV_UP;
               press_mode = MODE_UP;
            end
         end
      endcase
      if (fires) begin
         ticks_since = '0;
      end
   endfunction

   // Offer one tick word. Entered and left at a falling edge; valid stays high
   // on return so a back-to-back word keeps it up without a glitch.
   task automatic send_tick(input logic lvl, input bit typed, input bit typed_fires,
                            input bgd_pkg::event_type typed_code);
      int                 gap;
      bit                 fires;
      bgd_pkg::event_type code;
      gap = $urandom_range(0, send_cap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_level <= lvl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_gesture(lvl, fires, code);
      // hand-typed rows override the predictor's event but keep its state moving
      if (typed) begin
         if (typed_fires) pending_events.push_back(typed_code);
      end else if (fires) begin
         pending_events.push_back(code);
      end
      last_level = lvl;
      @(negedge clock);
   endtask

   // Drop valid, wait until every event has come back, then let the pipe settle.
   task automatic drain_events();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input logic [bgd_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [bgd_pkg::CSR_DATA_WIDTH-1:0] data);
      drain_events();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         bgd_pkg::CSR_ACTIVE_LEVEL: cfg_active = data[0];
         bgd_pkg::CSR_LONG_PRESS:   cfg_long   = data;
         bgd_pkg::CSR_DOUBLE_CLICK: cfg_double = data;
         default:                   ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Limits mostly small so presses cross them often; now and then an extreme.
   function automatic logic [bgd_pkg::LIMIT_WIDTH-1:0] draw_limit(input int span);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return bgd_pkg::LIMIT_WIDTH'($urandom_range(0, span));
      endcase
   endfunction

   // One random phase: alternating press and release runs whose lengths cluster
   // around the limit that applies, or plain noise on some phases.
   task automatic run_gesture_phase(input int n_ticks);
      int   sent;
      int   run;
      int   limit;
      bit   noise;
      logic lvl;
      sent  = 0;
      noise = ($urandom_range(0, 4) == 0);
      lvl   = last_level;
      while (sent < n_ticks) begin
         if (noise) begin
            lvl = 1'($urandom_range(0, 1));
            run = 1;
         end else begin
            lvl   = ~lvl;
            limit = (lvl == cfg_active) ? int'(cfg_long) : int'(cfg_double);
            case ($urandom_range(0, 2))
               0: run = $urandom_range(1, 3);
               1: run = (limit <= 40) ? limit + $urandom_range(0, 3) - 1
                                      : $urandom_range(1, 45);
               default: run = $urandom_range(1, 45);
            endcase
            if (run < 1) run = 1;
         end
         for (int k = 0; k < run && sent < n_ticks; k++) begin
            send_tick(lvl, 1'b0, 1'b0, bgd_pkg::EV_DOWN);
            sent++;
         end
      end
   endtask

   // Result side: random back-pressure, one long hold-off, and the compare.
   initial begin : result_side
      int                 stall;
      bgd_pkg::event_type want;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (events_seen == HOLD_AT_EVENT) begin
            // hold off long enough for the event register to fill and stall ticks
            stall = HOLD_CYCLES;
         end else begin
            stall = $urandom_range(0, recv_cap);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_events.size() == 0) begin
            mismatches++;
            $display("%0t: event word %0d arrived with none expected",
                     $time, rsp_event_code);
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_code !== want) begin
               mismatches++;
               $display("%0t: event_code mismatch, expected %0d (%s), got %0d",
                        $time, want, want.name(), rsp_event_code);
            end
         end
         events_seen++;
         @(negedge clock);
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int random_sent;
      int n_ticks;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows, run against the reset register values first.
      foreach (directed_script[r]) begin
         if (directed_script[r].kind == DO_CSR) begin
            write_csr(directed_script[r].index, directed_script[r].data);
         end else begin
            send_tick(directed_script[r].level, directed_script[r].kind != TICK_PREDICTED,
                      directed_script[r].kind == TICK_EVENT, directed_script[r].code);
         end
      end

      // Random phases, each with a fresh register setting and idle pattern.
      random_sent = 0;
      while (random_sent < RANDOM_TICKS) begin
         write_csr(bgd_pkg::CSR_ACTIVE_LEVEL, bgd_pkg::CSR_DATA_WIDTH'($urandom));
         write_csr(bgd_pkg::CSR_LONG_PRESS, draw_limit(40));
         write_csr(bgd_pkg::CSR_DOUBLE_CLICK, draw_limit(25));
         if ($urandom_range(0, 3) == 0) begin
            write_csr(CSR_SPARE, bgd_pkg::CSR_DATA_WIDTH'($urandom));
         end
         // on each side, a quarter of the phases run with no idling there
         send_cap = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
         recv_cap = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
         n_ticks  = $urandom_range(60, 150);
         run_gesture_phase(n_ticks);
         random_sent += n_ticks;
      end

      drain_events();
      repeat (3) @(negedge clock);
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/bgd_pkg.sv
rtl/core/bgd_csr.sv
rtl/core/bgd_fsm.sv
rtl/core/button_gesture_detector.sv
bench/testbench.sv
